>>> hw/rtl/bcc_pkg.sv
// Package for the button click classifier: payload structs, per-button state record,
// register indexes and reset values. No dependencies.
`default_nettype none
package bcc_pkg;

    localparam int NUM_BUTTONS_DEF = 2;

    localparam int CFG_IDX_W = 1;
    localparam logic [CFG_IDX_W-1:0] CFG_DOUBLE_WINDOW  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_LONG_THRESHOLD = 1'b1;

    localparam logic [31:0] DOUBLE_WINDOW_RST  = 32'd250;
    localparam logic [31:0] LONG_THRESHOLD_RST = 32'd1000;
    localparam logic [15:0] HOLD_MAX           = 16'hFFFF;

    typedef struct packed {
        logic        button_id;
        logic        level;
        logic [31:0] now;
        logic        ack_single;
        logic        ack_double;
    } t_in;

    typedef struct packed {
        logic        pressed;
        logic        single_flag;
        logic        double_flag;
        logic        long_flag;
        logic [15:0] hold_ticks;
    } t_out;

    typedef struct packed {
        logic        press_valid;
        logic        release_valid;
        logic [31:0] press_start_time;
        logic [31:0] release_time;
        logic        single_pending;
        logic        double_pending;
        logic        long_active;
        logic [15:0] hold_count;
    } t_btn_state;

endpackage
`default_nettype wire

>>> hw/rtl/button_click_classifier.sv
// Top level of the button click classifier: configuration registers, request pipeline
// and output register. Depends on bcc_pkg, bcc_state_mem and bcc_update.
//
//   Channel   Direction  Handshake                Payload
//   in        sink       i_in_valid / o_in_stall  i_in_data (t_in)
//   out       source     o_out_valid / i_out_stall o_out_data (t_out)
//   cfg       sink       i_cfg_valid / o_cfg_ready i_cfg_index, i_cfg_data
//
// One request per cycle sustained while the output is not stalled; each request passes
// through the request stage and then the output register. The rate is set by the single
// read port and single write port of the state memory, with a bypass covering back-to-back requests to the same button.
// Reset clears the per-button valid bits at once; no clearing pass is needed.
// A stalled output holds the pipeline; the input side stalls once the request stage is full.
`default_nettype none
module button_click_classifier #(
    parameter int NUM_BUTTONS = bcc_pkg::NUM_BUTTONS_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire logic                          i_in_valid,
    output logic                               o_in_stall,
    input  wire bcc_pkg::t_in                  i_in_data,
    output logic                               o_out_valid,
    input  wire logic                          i_out_stall,
    output bcc_pkg::t_out                      o_out_data,
    input  wire logic                          i_cfg_valid,
    output logic                               o_cfg_ready,
    input  wire logic [bcc_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  wire logic [31:0]                   i_cfg_data
);
    import bcc_pkg::*;

    localparam int AW = (NUM_BUTTONS > 1) ? $clog2(NUM_BUTTONS) : 1;

    logic [31:0] r_double_window;
    logic [31:0] r_long_threshold;
    logic        r_s1_valid;
    t_in         r_s1_item;
    logic        r_out_valid;
    t_out        r_out_data;

    logic        adv;
    logic        accept;
    logic        s1_in_range;
    logic        wr_en;
    t_btn_state  rd_state;
    t_btn_state  wr_state;
    t_out        result;

    assign o_cfg_ready = 1'b1;
    assign adv         = !r_out_valid || !i_out_stall;
    assign o_in_stall  = r_s1_valid && !adv;
    assign accept      = i_in_valid && !o_in_stall;
    assign s1_in_range = 32'(r_s1_item.button_id) < 32'(NUM_BUTTONS);
    assign wr_en       = r_s1_valid && adv && s1_in_range;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_double_window  <= DOUBLE_WINDOW_RST;
            r_long_threshold <= LONG_THRESHOLD_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (i_cfg_index)
                CFG_DOUBLE_WINDOW: begin
                    r_double_window <= i_cfg_data;
                end
                CFG_LONG_THRESHOLD: begin
                    r_long_threshold <= i_cfg_data;
                end
            endcase
        end
    end

    bcc_state_mem #(
        .NUM_BUTTONS (NUM_BUTTONS),
        .AW          (AW)
    ) u_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_rd_en   (accept),
        .i_rd_addr (AW'(i_in_data.button_id)),
        .o_rd_data (rd_state),
        .i_wr_en   (wr_en),
        .i_wr_addr (AW'(r_s1_item.button_id)),
        .i_wr_data (wr_state)
    );

    bcc_update u_update (
        .i_state          (rd_state),
        .i_item           (r_s1_item),
        .i_in_range       (s1_in_range),
        .i_double_window  (r_double_window),
        .i_long_threshold (r_long_threshold),
        .o_state          (wr_state),
        .o_result         (result)
    );

    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_item <= i_in_data;
        end
        if (adv) begin
            r_out_data <= result;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (adv) begin
                r_s1_valid  <= accept;
                r_out_valid <= r_s1_valid;
            end else if (accept) begin
                r_s1_valid <= 1'b1;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;

endmodule
`default_nettype wire

>>> hw/rtl/bcc_state_mem.sv
// Per-button state memory with a registered read, per-entry valid bits
// and a write-to-read bypass. Depends on bcc_pkg.
`default_nettype none
module bcc_state_mem #(
    parameter int NUM_BUTTONS = 2,
    parameter int AW          = 1
) (
    input  wire logic                   i_clk,
    input  wire logic                   i_rst_n,
    input  wire logic                   i_rd_en,
    input  wire logic [AW-1:0]          i_rd_addr,
    output bcc_pkg::t_btn_state         o_rd_data,
    input  wire logic                   i_wr_en,
    input  wire logic [AW-1:0]          i_wr_addr,
    input  wire bcc_pkg::t_btn_state    i_wr_data
);
    import bcc_pkg::*;

    t_btn_state r_mem [NUM_BUTTONS];
    logic [NUM_BUTTONS-1:0] r_ent_vld;
    t_btn_state r_rd_q;
    logic r_rd_vld;
    logic r_byp_hit;
    t_btn_state r_byp_data;

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_q     <= r_mem[i_rd_addr];
            r_byp_data <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ent_vld <= '0;
            r_rd_vld  <= 1'b0;
            r_byp_hit <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_ent_vld[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_vld  <= r_ent_vld[i_rd_addr];
                r_byp_hit <= i_wr_en && (i_wr_addr == i_rd_addr);
            end
        end
    end

    always_comb begin
        if (r_byp_hit) begin
            o_rd_data = r_byp_data;
        end else if (r_rd_vld) begin
            o_rd_data = r_rd_q;
        end else begin
            o_rd_data = '0;
        end
    end

endmodule
`default_nettype wire

>>> hw/rtl/bcc_update.sv
// Next-state and result logic for one button: press, release, double window,
// long press and hold counting. Depends on bcc_pkg.
`default_nettype none
module bcc_update (
    input  wire bcc_pkg::t_btn_state  i_state,
    input  wire bcc_pkg::t_in         i_item,
    input  wire logic                 i_in_range,
    input  wire logic [31:0]          i_double_window,
    input  wire logic [31:0]          i_long_threshold,
    output bcc_pkg::t_btn_state       o_state,
    output bcc_pkg::t_out             o_result
);
    import bcc_pkg::*;

    t_btn_state s;
    logic       down;
    logic [31:0] rel_diff;
    logic [31:0] hold_diff;
    logic [31:0] win_diff;

    always_comb begin
        s    = i_state;
        down = !i_item.level;
        if (i_item.ack_single) begin
            s.single_pending = 1'b0;
        end
        if (i_item.ack_double) begin
            s.double_pending = 1'b0;
        end
        rel_diff = i_item.now - i_state.release_time;
        if (down) begin
            if (!i_state.press_valid) begin
                s.press_valid      = 1'b1;
                s.press_start_time = i_item.now;
                if (i_state.release_valid && (rel_diff < i_double_window)) begin
                    s.double_pending = 1'b1;
                    s.release_valid  = 1'b0;
                end
            end
            hold_diff = i_item.now - s.press_start_time;
            if (hold_diff >= i_long_threshold) begin
                if (!i_state.long_active) begin
                    s.hold_count = '0;
                end
                s.long_active = 1'b1;
                if (s.hold_count != HOLD_MAX) begin
                    s.hold_count = s.hold_count + 16'd1;
                end
            end
        end else begin
            hold_diff = '0;
            if (i_state.press_valid) begin
                s.release_time     = i_item.now;
                s.release_valid    = 1'b1;
                s.press_valid      = 1'b0;
                s.press_start_time = '0;
            end
            s.long_active = 1'b0;
            s.hold_count  = '0;
        end
        win_diff = i_item.now - s.release_time;
        if (s.release_valid && (win_diff >= i_double_window) && !s.double_pending) begin
            s.single_pending = 1'b1;
            s.release_valid  = 1'b0;
        end
        o_state = s;
        if (i_in_range) begin
            o_result.pressed     = s.press_valid;
            o_result.single_flag = s.single_pending;
            o_result.double_flag = s.double_pending;
            o_result.long_flag   = s.long_active;
            o_result.hold_ticks  = s.hold_count;
        end else begin
            o_result = '0;
        end
    end

endmodule
`default_nettype wire
